[src/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tcw_pkg;

	// Field widths of the request and response items.
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 4;
	localparam int IN_ADDR_W  = 11;
	localparam int OUT_ROW_W  = 5;
	localparam int OUT_COL_W  = 7;
	localparam int OUT_POS_W  = 11;
	localparam int CELL_W     = CHAR_W + 2 * COLOR_W;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_FG   = 1'b0;
	localparam logic REG_BG   = 1'b1;
	localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

	// Request command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Character codes with special meaning.
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;         // request channel is ready
		logic exec;         // apply the captured request
		logic sweep_en;     // write one cell of a sweep this cycle
		logic sweep_clear;  // sweep is the post-reset clear, else a row erase
		logic finish;       // load the response register
	} tcw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_valid;
		logic is_read;
		logic need_scroll;
		logic sweep_last;
		logic out_free;
	} tcw_stat_t;

endpackage

`default_nettype wire

[src/tcw_if.sv]
// Request and response channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_req_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [CHAR_W-1:0]    char_code;
	logic [IN_ADDR_W-1:0] read_address;
	logic                 last_in_call;

	modport source (output valid, command, char_code, read_address, last_in_call,
		input ready);
	modport sink (input valid, command, char_code, read_address, last_in_call,
		output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OUT_ROW_W-1:0] cursor_line;
	logic [OUT_COL_W-1:0] cursor_column;
	logic [OUT_POS_W-1:0] cursor_position;
	logic                 cursor_update;
	logic                 scrolled;
	logic [CHAR_W-1:0]    cell_char;
	logic [COLOR_W-1:0]   cell_foreground;
	logic [COLOR_W-1:0]   cell_background;

	modport source (output valid, cursor_line, cursor_column, cursor_position, cursor_update,
		scrolled, cell_char, cell_foreground, cell_background, input ready);
	modport sink (input valid, cursor_line, cursor_column, cursor_position, cursor_update,
		scrolled, cell_char, cell_foreground, cell_background, output ready);
endinterface

`default_nettype wire

[src/tcw_ctrl.sv]
// Controller of the text console writer: sequences clear, execute, row erase
// and response load. Depends on tcw_pkg for the command and status structs.
`default_nettype none

module tcw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t       cmd
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (stat.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (stat.req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (stat.is_read) state_q <= ST_FINISH;
					else if (stat.need_scroll) state_q <= ST_SCROLL;
					else if (stat.out_free) state_q <= ST_IDLE;
					else state_q <= ST_FINISH;
				end
				ST_SCROLL: begin
					if (stat.sweep_last) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep_en    = 1'b1;
				cmd.sweep_clear = 1'b1;
			end
			ST_IDLE: begin
				cmd.take = 1'b1;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				// A write that needs no scroll reports in the same cycle when the response register is free.
				cmd.finish = !stat.is_read && !stat.need_scroll && stat.out_free;
			end
			ST_SCROLL: begin
				cmd.sweep_en = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/tcw_datapath.sv]
// Datapath of the text console writer: screen memory kept as a ring of rows,
// cursor registers, sweep counter and the response register. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tcw_pkg::tcw_cmd_t          cmd,
	output tcw_pkg::tcw_stat_t              stat,
	input  wire logic [tcw_pkg::COLOR_W-1:0] fg,
	input  wire logic [tcw_pkg::COLOR_W-1:0] bg,
	tcw_req_if.sink                         req,
	tcw_rsp_if.source                       rsp
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam int SW = ((AW > IN_ADDR_W) ? AW : IN_ADDR_W) + 1;

	localparam logic [SW-1:0] CELLS_W     = SW'(CELL_COUNT);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] LAST_BASE   = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_SWP    = AW'(COLUMNS - 1);
	localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

	// Captured request.
	logic              is_read_q;
	logic [CHAR_W-1:0] ch_q;
	logic              last_q;
	logic              inrange_q;
	logic [AW-1:0]     phys_q;

	// Cursor and ring state. top_q is the physical start of the top row.
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] top_q;
	logic [AW-1:0] swp_q;
	logic          scr_q;

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rd_q;

	// Response register.
	logic                 rsp_valid_q;
	logic [OUT_ROW_W-1:0] o_row_q;
	logic [OUT_COL_W-1:0] o_col_q;
	logic [OUT_POS_W-1:0] o_pos_q;
	logic                 o_upd_q;
	logic                 o_scr_q;
	logic [CELL_W-1:0]    o_cell_q;

	logic              cap;
	logic              in_rng;
	logic [SW-1:0]     base_w;
	logic [SW-1:0]     sum_w;
	logic [AW-1:0]     phys_c;
	logic              wrap;
	logic              on_last_row;
	logic              need_scroll;
	logic              adv;
	logic [RW-1:0]     row_c;
	logic [CW-1:0]     col_c;
	logic [AW-1:0]     pos_c;
	logic [RW-1:0]     row_o;
	logic [CW-1:0]     col_o;
	logic [AW-1:0]     pos_o;
	logic              sweep_last;
	logic              out_free;
	logic              we;
	logic [AW-1:0]     wa;
	logic [CELL_W-1:0] wd;
	logic [CELL_W-1:0] cell_o;

	assign req.ready = cmd.take;
	assign cap       = cmd.take && req.valid;

	// Logical to physical address: add the top row offset, wrap once.
	always_comb begin
		in_rng = SW'(req.read_address) < CELLS_W;
		base_w = (req.command == CMD_READ) ? SW'(req.read_address) : SW'(pos_q);
		sum_w  = base_w + SW'(top_q);
		if (sum_w >= CELLS_W) sum_w = sum_w - CELLS_W;
		phys_c = AW'(sum_w);
		if (req.command == CMD_READ && !in_rng) phys_c = '0;
	end

	always_comb begin
		wrap        = (ch_q == NEWLINE_CODE) || (col_q == LAST_COL);
		on_last_row = row_q == LAST_ROW;
		need_scroll = !is_read_q && wrap && on_last_row;
		if (wrap) begin
			col_c = '0;
			if (on_last_row) begin
				row_c = row_q;
				pos_c = LAST_BASE;
			end else begin
				row_c = row_q + RW'(1);
				pos_c = AW'((AW+1)'(pos_q) + (AW+1)'(COLUMNS) - (AW+1)'(col_q));
			end
		end else begin
			row_c = row_q;
			col_c = col_q + CW'(1);
			pos_c = pos_q + AW'(1);
		end
	end

	assign adv   = cmd.exec && !is_read_q;
	assign row_o = adv ? row_c : row_q;
	assign col_o = adv ? col_c : col_q;
	assign pos_o = adv ? pos_c : pos_q;

	assign sweep_last = cmd.sweep_clear ? (swp_q == LAST_CELL) : (swp_q == LAST_SWP);
	assign out_free   = !rsp_valid_q || rsp.ready;

	always_comb begin
		stat.req_valid   = req.valid;
		stat.is_read     = is_read_q;
		stat.need_scroll = need_scroll;
		stat.sweep_last  = sweep_last;
		stat.out_free    = out_free;
	end

	// Memory write port: sweeps, else the character write.
	always_comb begin
		if (cmd.sweep_en) begin
			we = 1'b1;
			wa = cmd.sweep_clear ? swp_q : top_q + swp_q;
			wd = cmd.sweep_clear ? '0 : {bg, fg, SPACE_CODE};
		end else begin
			we = adv && (ch_q != NEWLINE_CODE);
			wa = phys_q;
			wd = {bg, fg, ch_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[phys_q];
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			is_read_q <= req.command == CMD_READ;
			ch_q      <= req.char_code;
			last_q    <= req.last_in_call;
			inrange_q <= in_rng;
			phys_q    <= phys_c;
		end
		if (cmd.exec) scr_q <= need_scroll;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pos_q <= '0;
			top_q <= '0;
			swp_q <= '0;
		end else begin
			if (adv) begin
				row_q <= row_c;
				col_q <= col_c;
				pos_q <= pos_c;
			end
			if (cmd.sweep_en) begin
				swp_q <= sweep_last ? '0 : swp_q + AW'(1);
			end else begin
				swp_q <= '0;
			end
			// After the old top row is erased it becomes the bottom row.
			if (cmd.sweep_en && !cmd.sweep_clear && sweep_last) begin
				top_q <= (top_q == CELLS_W[AW-1:0] - COLS_A && CELL_COUNT > COLUMNS
					&& top_q == LAST_BASE) ? '0 : top_q + COLS_A;
			end
		end
	end

	assign cell_o = (is_read_q && inrange_q) ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			o_row_q  <= OUT_ROW_W'(row_o);
			o_col_q  <= OUT_COL_W'(col_o);
			o_pos_q  <= OUT_POS_W'(pos_o);
			o_upd_q  <= !is_read_q && last_q;
			o_scr_q  <= cmd.exec ? need_scroll : scr_q;
			o_cell_q <= cell_o;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.cursor_line     = o_row_q;
	assign rsp.cursor_column   = o_col_q;
	assign rsp.cursor_position = o_pos_q;
	assign rsp.cursor_update   = o_upd_q;
	assign rsp.scrolled        = o_scr_q;
	assign rsp.cell_char       = o_cell_q[CHAR_W-1:0];
	assign rsp.cell_foreground = o_cell_q[CHAR_W +: COLOR_W];
	assign rsp.cell_background = o_cell_q[CHAR_W+COLOR_W +: COLOR_W];

endmodule

`default_nettype wire

[src/text_console_writer_top.sv]
// Channel   Direction  Handshake      Payload
// req       in         valid/ready    command, char_code, read_address, last_in_call
// rsp       out        valid/ready    cursor, position, update, scrolled, cell fields
// apb       in         psel/penable   text_foreground at 0x0, text_background at 0x4
//
// A character or newline request passes through the execute state; a cell read then also
// passes through the finish state. In a request that scrolls, the ring of rows advances
// and the old top row is erased one cell a cycle through the memory write port.
// After reset the screen memory is cleared one cell a cycle while req.ready stays low;
// register writes are taken meanwhile.
// A new request is taken while the previous response waits in rsp.
// Depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_datapath.
`default_nettype none

module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tcw_req_if.sink                            req,
	tcw_rsp_if.source                          rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [tcw_pkg::APB_DATA_W-1:0] prdata,
	output logic                               pready
);
	import tcw_pkg::*;

	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               reg_sel;
	logic               cfg_wr;
	tcw_cmd_t           cmd;
	tcw_stat_t          stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == REG_FG) fg_q <= pwdata[COLOR_W-1:0];
			else bg_q <= pwdata[COLOR_W-1:0];
		end
	end

	assign prdata = APB_DATA_W'((reg_sel == REG_BG) ? bg_q : fg_q);

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.fg     (fg_q),
		.bg     (bg_q),
		.req    (req),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	// No request is taken while the memory is being swept.
	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_en |-> !req.ready)
		else $error("request channel ready during a memory sweep");

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while the previous one is still in work");

	// A scroll always leaves the cursor at the start of the last row.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.scrolled) |->
		(rsp.cursor_column == '0 && rsp.cursor_line == OUT_ROW_W'(ROWS - 1)))
		else $error("scroll reported with the cursor off the last row start");
`endif

endmodule

`default_nettype wire
